// ===== hdl/vna_pkg.sv =====
// vertex normal accumulator package: transfer structs, request codes, defaults
// used by vertex_normal_accumulator; no dependencies
package vna_pkg;

	localparam int VERTEX_DEPTH_DEF = 1024;
	localparam int COORD_WIDTH_DEF  = 16;
	localparam int ACCUM_WIDTH_DEF  = 40;

	localparam int IDX_W  = 10;
	localparam int POS_W  = 16;
	localparam int UNIT_W = 16;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_TRI  = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t                req_type;
		logic [IDX_W-1:0]         vtx_index;
		logic [IDX_W-1:0]         corner_b_index;
		logic [IDX_W-1:0]         corner_c_index;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_index;
		logic signed [UNIT_W-1:0] unit_x;
		logic signed [UNIT_W-1:0] unit_y;
		logic signed [UNIT_W-1:0] unit_z;
		logic                     degenerate;
	} rsp_t;

endpackage

// ===== hdl/vertex_normal_accumulator.sv =====
// channel | valid     | stall     | payload
// req     | req_valid | req_stall | req (req_t)
// rsp     | rsp_valid | rsp_stall | rsp (rsp_t)
// triangle: three position reads, three cross product steps, and a read and write
// back of each corner accumulator on the single-port memory; read: a 1 to 24 step
// shift search, the 26-step square root and three divides. one item at a time; a
// finished result sits in the output register, so a new item is taken while it
// waits. reset clears control only, memories hold garbage until loaded.
// depends on vna_pkg
module vertex_normal_accumulator
	import vna_pkg::*;
#(
	parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int ACCUM_WIDTH  = ACCUM_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CW     = COORD_WIDTH;
	localparam int AW     = ACCUM_WIDTH;
	localparam int ADDR_W = $clog2(VERTEX_DEPTH);
	localparam int NW     = 2 * CW + 3;
	localparam int SUMW   = ((NW > AW) ? NW : AW) + 1;
	localparam int SQW    = 52;
	localparam int REMW   = 41;
	localparam int LW     = 25;
	localparam logic signed [SUMW-1:0] ACC_HI = {{(SUMW-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [SUMW-1:0] ACC_LO = ~ACC_HI;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_VRD   = 14'b00000000000010,
		S_VLAST = 14'b00000000000100,
		S_CROSS = 14'b00000000001000,
		S_ARD   = 14'b00000000010000,
		S_AWR   = 14'b00000000100000,
		S_RRD   = 14'b00000001000000,
		S_RABS  = 14'b00000010000000,
		S_RNORM = 14'b00000100000000,
		S_RSQ   = 14'b00001000000000,
		S_RSQRT = 14'b00010000000000,
		S_RDIVI = 14'b00100000000000,
		S_RDIV  = 14'b01000000000000,
		S_RDONE = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic [1:0] cnt_q;
	logic [1:0] rsel_q;
	logic [3:0] di_q;
	logic [IDX_W-1:0] idx_q [3];
	logic signed [CW-1:0] px_q [3];
	logic signed [CW-1:0] py_q [3];
	logic signed [CW-1:0] pz_q [3];
	logic signed [NW-1:0] n_q [3];
	logic [AW-1:0] mag_q [3];
	logic sg_q [3];
	logic [SQW-1:0] s_q;
	logic [SQW-1:0] res_q;
	logic [SQW-1:0] bit_q;
	logic [REMW-1:0] rem_q;
	logic [UNIT_W-1:0] quo_q;
	logic [UNIT_W-1:0] unit_q [3];
	logic deg_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [3*CW-1:0] vmem [VERTEX_DEPTH];
	logic [3*CW-1:0] vrdata_q;
	logic [3*AW-1:0] amem [VERTEX_DEPTH];
	logic [3*AW-1:0] ardata_q;

	logic accept;
	logic a_ok, b_ok, c_ok;
	logic v_we, a_we;
	logic [ADDR_W-1:0] v_addr, a_addr;
	logic [3*CW-1:0] v_wdata;
	logic [3*AW-1:0] a_wdata;
	logic signed [CW:0] e1x, e1y, e1z, e2x, e2y, e2z;
	logic signed [CW:0] op_a, op_b, op_c, op_d;
	logic signed [2*CW+1:0] prod_0, prod_1;
	logic signed [AW-1:0] acc_x, acc_y, acc_z;
	logic any_hi, all_lo;
	logic [23:0] sq_op;
	logic [47:0] sq_prod;
	logic [SQW-1:0] sq_try;
	logic [LW-1:0] root;
	logic [REMW-1:0] div_try;
	logic [UNIT_W-1:0] quo_next;
	logic rsp_free;

	function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
			input logic signed [NW-1:0] b);
		logic signed [SUMW-1:0] s;
		s = SUMW'(a) + SUMW'(b);
		if (s > ACC_HI) return AW'(ACC_HI);
		else if (s < ACC_LO) return AW'(ACC_LO);
		else return AW'(s);
	endfunction

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign a_ok      = (32'(req.vtx_index) < 32'(VERTEX_DEPTH));
	assign b_ok      = (32'(req.corner_b_index) < 32'(VERTEX_DEPTH));
	assign c_ok      = (32'(req.corner_c_index) < 32'(VERTEX_DEPTH));
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// memory port control
	always_comb begin
		v_we    = 1'b0;
		a_we    = 1'b0;
		v_addr  = ADDR_W'(idx_q[cnt_q]);
		a_addr  = ADDR_W'(idx_q[cnt_q]);
		v_wdata = {CW'(req.pos_x), CW'(req.pos_y), CW'(req.pos_z)};
		a_wdata = {acc_x, acc_y, acc_z};
		if (state_q == S_IDLE) begin
			v_addr = ADDR_W'(req.vtx_index);
			a_addr = ADDR_W'(req.vtx_index);
			if (accept && req.req_type == REQ_LOAD && a_ok) begin
				v_we    = 1'b1;
				a_we    = 1'b1;
				a_wdata = '0;
			end
		end else if (state_q == S_AWR) begin
			a_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_we) vmem[v_addr] <= v_wdata;
		else vrdata_q <= vmem[v_addr];
	end

	always_ff @(posedge clk) begin
		if (a_we) amem[a_addr] <= a_wdata;
		else ardata_q <= amem[a_addr];
	end

	// edges and cross product, one component a cycle
	assign e1x = (CW+1)'(px_q[1]) - (CW+1)'(px_q[0]);
	assign e1y = (CW+1)'(py_q[1]) - (CW+1)'(py_q[0]);
	assign e1z = (CW+1)'(pz_q[1]) - (CW+1)'(pz_q[0]);
	assign e2x = (CW+1)'(px_q[2]) - (CW+1)'(px_q[0]);
	assign e2y = (CW+1)'(py_q[2]) - (CW+1)'(py_q[0]);
	assign e2z = (CW+1)'(pz_q[2]) - (CW+1)'(pz_q[0]);

	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = e1y; op_b = e2z; op_c = e1z; op_d = e2y;
			end
			2'd1: begin
				op_a = e1z; op_b = e2x; op_c = e1x; op_d = e2z;
			end
			default: begin
				op_a = e1x; op_b = e2y; op_c = e1y; op_d = e2x;
			end
		endcase
	end

	assign prod_0 = op_a * op_b;
	assign prod_1 = op_c * op_d;

	assign acc_x = sat_add(ardata_q[3*AW-1:2*AW], n_q[0]);
	assign acc_y = sat_add(ardata_q[2*AW-1:AW], n_q[1]);
	assign acc_z = sat_add(ardata_q[AW-1:0], n_q[2]);

	// normalization datapath
	assign any_hi = (mag_q[0][AW-1:24] != '0) || (mag_q[1][AW-1:24] != '0)
		|| (mag_q[2][AW-1:24] != '0);
	assign all_lo = (mag_q[0][AW-1:23] == '0) && (mag_q[1][AW-1:23] == '0)
		&& (mag_q[2][AW-1:23] == '0);
	assign sq_op    = mag_q[cnt_q][23:0];
	assign sq_prod  = sq_op * sq_op;
	assign sq_try   = res_q + bit_q;
	assign root     = res_q[LW-1:0];
	assign div_try  = REMW'(root) << di_q;
	assign quo_next = (rem_q >= div_try) ? (quo_q | (UNIT_W'(1) << di_q)) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsel_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_RDONE) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						unique case (req.req_type)
							REQ_TRI: if (a_ok && b_ok && c_ok) state_q <= S_VRD;
							REQ_READ: state_q <= a_ok ? S_RRD : S_RDONE;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_VRD: begin
					rsel_q <= cnt_q;
					if (cnt_q == 2'd2) begin
						state_q <= S_VLAST;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				S_VLAST: state_q <= S_CROSS;
				S_CROSS: begin
					if (cnt_q == 2'd2) begin
						state_q <= S_ARD;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				S_ARD: state_q <= S_AWR;
				S_AWR: begin
					if (cnt_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q   <= cnt_q + 2'd1;
						state_q <= S_ARD;
					end
				end
				S_RRD: state_q <= S_RABS;
				S_RABS: begin
					if (ardata_q == '0) state_q <= S_RDONE;
					else state_q <= S_RNORM;
				end
				S_RNORM: begin
					if (!any_hi && !all_lo) begin
						state_q <= S_RSQ;
						cnt_q   <= '0;
					end
				end
				S_RSQ: begin
					if (cnt_q == 2'd2) state_q <= S_RSQRT;
					else cnt_q <= cnt_q + 2'd1;
				end
				S_RSQRT: begin
					if (bit_q == SQW'(1)) begin
						state_q <= S_RDIVI;
						cnt_q   <= '0;
					end
				end
				S_RDIVI: state_q <= S_RDIV;
				S_RDIV: begin
					if (di_q == 4'd0) begin
						if (cnt_q == 2'd2) begin
							state_q <= S_RDONE;
						end else begin
							cnt_q   <= cnt_q + 2'd1;
							state_q <= S_RDIVI;
						end
					end
				end
				S_RDONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				idx_q[0] <= req.vtx_index;
				idx_q[1] <= req.corner_b_index;
				idx_q[2] <= req.corner_c_index;
				deg_q    <= 1'b1;
				for (int k = 0; k < 3; k++) unit_q[k] <= '0;
			end
			S_VRD, S_VLAST: begin
				if (state_q == S_VLAST || cnt_q != 2'd0) begin
					px_q[rsel_q] <= vrdata_q[3*CW-1:2*CW];
					py_q[rsel_q] <= vrdata_q[2*CW-1:CW];
					pz_q[rsel_q] <= vrdata_q[CW-1:0];
				end
			end
			S_CROSS: n_q[cnt_q] <= NW'(prod_0) - NW'(prod_1);
			S_RABS: begin
				sg_q[0]  <= ardata_q[3*AW-1];
				sg_q[1]  <= ardata_q[2*AW-1];
				sg_q[2]  <= ardata_q[AW-1];
				mag_q[0] <= ardata_q[3*AW-1] ? (~ardata_q[3*AW-1:2*AW] + AW'(1))
					: ardata_q[3*AW-1:2*AW];
				mag_q[1] <= ardata_q[2*AW-1] ? (~ardata_q[2*AW-1:AW] + AW'(1))
					: ardata_q[2*AW-1:AW];
				mag_q[2] <= ardata_q[AW-1] ? (~ardata_q[AW-1:0] + AW'(1))
					: ardata_q[AW-1:0];
				s_q      <= '0;
			end
			S_RNORM: begin
				deg_q <= 1'b0;
				for (int k = 0; k < 3; k++) begin
					if (any_hi) mag_q[k] <= mag_q[k] >> 1;
					else if (all_lo) mag_q[k] <= mag_q[k] << 1;
				end
			end
			S_RSQ: begin
				s_q   <= s_q + SQW'(sq_prod);
				res_q <= '0;
				bit_q <= SQW'(1) << 50;
			end
			S_RSQRT: begin
				// one root bit per step
				if (s_q >= sq_try) begin
					s_q   <= s_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_RDIVI: begin
				rem_q <= REMW'({mag_q[cnt_q][23:0], 14'b0}) + REMW'(root >> 1);
				quo_q <= '0;
				di_q  <= 4'd15;
			end
			S_RDIV: begin
				if (rem_q >= div_try) rem_q <= rem_q - div_try;
				quo_q <= quo_next;
				di_q  <= di_q - 4'd1;
				if (di_q == 4'd0)
					unit_q[cnt_q] <= sg_q[cnt_q] ? (~quo_next + UNIT_W'(1)) : quo_next;
			end
			S_RDONE: begin
				if (rsp_free) begin
					rsp_q.out_index  <= idx_q[0];
					rsp_q.unit_x     <= unit_q[0];
					rsp_q.unit_y     <= unit_q[1];
					rsp_q.unit_z     <= unit_q[2];
					rsp_q.degenerate <= deg_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
